// File: hw/rtl/crb64_pkg.sv
// Shared types, constants and the base64 alphabet for the scrubbing encoder.
package crb64_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [7:0] CR_BYTE        = 8'h0d;
   localparam logic [7:0] SPACE_BYTE     = 8'h20;
   localparam logic [6:0] PAD_CHAR       = 7'h3d;
   localparam logic       CR_SCRUB_RESET = 1'b1;

   // Group sizes and character slots.
   localparam logic [1:0] GRP_ONE   = 2'd1;
   localparam logic [1:0] GRP_TWO   = 2'd2;
   localparam logic [1:0] GRP_THREE = 2'd3;
   localparam logic [1:0] SLOT_0    = 2'd0;
   localparam logic [1:0] SLOT_1    = 2'd1;
   localparam logic [1:0] SLOT_2    = 2'd2;
   localparam logic [1:0] SLOT_3    = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic [6:0] code_char;
      logic       last_char;
   } rsp_word_type;

   // One byte group handed from the front end to the back end.
   typedef struct packed {
      logic [23:0] grp_bytes;
      logic [1:0]  grp_count;
      logic        grp_fin;
   } grp_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [6:0] b64_char(input logic [5:0] six);
      logic [6:0] v;
      v = {1'b0, six};
      if (six < 6'd26) begin
         return 7'h41 + v;
      end else if (six < 6'd52) begin
         return 7'h47 + v;
      end else if (six < 6'd62) begin
         return v - 7'd4;
      end else if (six == 6'd62) begin
         return 7'h2b;
      end else begin
         return 7'h2f;
      end
   endfunction

endpackage

// File: hw/rtl/crb64_front.sv
// Front end: scrubs carriage returns and packs bytes into groups of up to three.
module crb64_front import crb64_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   input  q_status_type q_status,
   output logic         push,
   output grp_type      push_grp
);

   logic        scrub_en_ff, scrub_en_in;
   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic [7:0]  b;
   logic        accept;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      scrub_en_in   = csr_wr_en ? csr_wr_data : scrub_en_ff;
      b             = (scrub_en_ff && req_data.data_byte == CR_BYTE) ? SPACE_BYTE
                                                                     : req_data.data_byte;
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      push          = 1'b0;
      push_grp      = '{grp_bytes: {held_bytes_ff, b}, grp_count: GRP_THREE,
                        grp_fin: req_data.last_byte};
      if (accept) begin
         if (held_count_ff == GRP_TWO) begin
            push          = 1'b1;
            held_count_in = '0;
            held_bytes_in = '0;
         end else if (req_data.last_byte) begin
            push          = 1'b1;
            held_count_in = '0;
            held_bytes_in = '0;
            if (held_count_ff == '0) begin
               push_grp.grp_bytes = {b, 16'h0000};
               push_grp.grp_count = GRP_ONE;
            end else begin
               push_grp.grp_bytes = {held_bytes_ff[7:0], b, 8'h00};
               push_grp.grp_count = GRP_TWO;
            end
         end else begin
            held_bytes_in = {held_bytes_ff[7:0], b};
            held_count_in = held_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_bytes_ff <= held_bytes_in;
      if (reset) begin
         scrub_en_ff   <= CR_SCRUB_RESET;
         held_count_ff <= '0;
      end else begin
         scrub_en_ff   <= scrub_en_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// File: hw/rtl/crb64_queue.sv
// Short register queue of byte groups between the front and back ends.
module crb64_queue import crb64_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  grp_type      push_grp,
   input  logic         pop,
   output grp_type      pop_grp,
   output q_status_type q_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   grp_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign pop_grp        = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_grp;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hw/rtl/crb64_back.sv
// Back end: one group gives four base64 characters, one per unstalled cycle.
module crb64_back import crb64_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  grp_type      pop_grp,
   output logic         pop,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   logic         active_ff, active_in;
   logic [1:0]   slot_ff, slot_in;
   grp_type      grp_ff, grp_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_data_ff, rsp_data_in;
   logic         out_load;
   logic [5:0]   sextet;
   logic         pad;

   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign pop       = !q_status.empty && (!active_ff || (out_load && slot_ff == SLOT_3));
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      unique case (slot_ff)
         SLOT_0:  sextet = grp_ff.grp_bytes[23:18];
         SLOT_1:  sextet = grp_ff.grp_bytes[17:12];
         SLOT_2:  sextet = grp_ff.grp_bytes[11:6];
         default: sextet = grp_ff.grp_bytes[5:0];
      endcase
      pad = (slot_ff == SLOT_2 && grp_ff.grp_count == GRP_ONE) ||
            (slot_ff == SLOT_3 && grp_ff.grp_count != GRP_THREE);

      active_in    = active_ff;
      slot_in      = slot_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in = active_ff;
         if (active_ff) begin
            rsp_data_in.code_char = pad ? PAD_CHAR : b64_char(sextet);
            rsp_data_in.last_char = grp_ff.grp_fin && slot_ff == SLOT_3;
            slot_in               = slot_ff + 2'd1;
            if (slot_ff == SLOT_3) begin
               active_in = 1'b0;
            end
         end
      end
      if (pop) begin
         active_in = 1'b1;
         slot_in   = SLOT_0;
         grp_in    = pop_grp;
      end
   end

   always_ff @(posedge clock) begin
      grp_ff      <= grp_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         active_ff    <= 1'b0;
         slot_ff      <= SLOT_0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hw/rtl/cr_scrub_base64_encoder.sv
// A word that completes a group passes a queue entry, the back-end group register and the
// output register before its first character shows. Throughput: one input word per cycle while
// the queue has room, one character per cycle out while rsp_stall is low, so the output side
// sets the sustained rate. The group queue (QUEUE_DEPTH entries) absorbs bursts; input stalls
// only while it is full. Reset is synchronous and active high: it empties the queue, drops held
// bytes and pending output, and sets carriage-return scrubbing on.
module cr_scrub_base64_encoder import crb64_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data
);

   // The front end scrubs each accepted word and gathers bytes into groups. A group is
   // pushed when it holds three bytes or when the word is marked last.
   logic         push;
   grp_type      push_grp;
   logic         pop;
   grp_type      pop_grp;
   q_status_type q_status;

   crb64_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_status    (q_status),
      .push        (push),
      .push_grp    (push_grp)
   );

   // The queue decouples the two sides, so a stalled output does not stop input
   // until the queue fills.
   crb64_queue #(
      .DEPTH (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_grp (push_grp),
      .pop      (pop),
      .pop_grp  (pop_grp),
      .q_status (q_status)
   );

   // The back end walks the four character slots of a group, padding short groups
   // with '=', and holds each character in an output register until it is taken.
   crb64_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop_grp   (pop_grp),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hw/rtl/crb64_checker.sv
// Port-level checker for the scrubbing base64 encoder, bound to the top level.
module crb64_checker import crb64_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_word_type rsp_data
);

   logic [1:0] pos_ff;
   logic       rsp_take;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Position of the next delivered character within its group of four.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= SLOT_0;
      end else if (rsp_take) begin
         pos_ff <= pos_ff + 2'd1;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled output word changed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.last_char |-> pos_ff == SLOT_3)
      else $error("last character flagged off the fourth slot");

   a_pad_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.code_char == PAD_CHAR |->
         (pos_ff == SLOT_2 || pos_ff == SLOT_3))
      else $error("pad character in a leading slot");

   a_pad_final: assert property (@(posedge clock) disable iff (reset)
      rsp_take && rsp_data.code_char == PAD_CHAR && pos_ff == SLOT_3 |->
         rsp_data.last_char)
      else $error("padded group not flagged as last");

endmodule

bind cr_scrub_base64_encoder crb64_checker u_crb64_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: verif/tb_cr_scrub_base64_encoder.sv
// Self-checking testbench for the carriage-return scrubbing base64 encoder.
`timescale 1ns / 1ps

module tb_cr_scrub_base64_encoder;
   import crb64_pkg::*;

   // The run stops here even if the block hangs.
   localparam int CYCLE_LIMIT = 200000;
   // Idle cycles after the last expected character.
   // Both the scrub register write and the final verdict wait this long.
   localparam int DRAIN_CYCLES = 10;
   localparam int DIRECTED_ROWS = 26;
   localparam int PHASES = 6;
   localparam int PHASE_BYTES = 22;
   localparam logic [31:0] NO_TYPED = 32'd0;

   // A directed row either sends one byte word or writes the scrub register.
   // For a register row, bit 0 of the byte field is the value written.
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_e;

   typedef struct packed {
      row_kind_e   kind;
      logic [7:0]  data_byte;
      logic        fin;
      logic [31:0] typed;   // four ASCII characters, or NO_TYPED
   } row_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_e;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic         csr_wr_data = 1'b0;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   cr_scrub_base64_encoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #5 clock = ~clock;

   // Encoder shadow state. The held bytes are stored after scrubbing, and the
   // older byte sits in the upper half when two are held.
   string        b64_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   logic         scrub_cr = CR_SCRUB_RESET;
   logic [15:0]  held_pair = '0;
   logic [1:0]   held_n = '0;
   rsp_word_type next_group [4];

   // Characters that the block still owes, oldest first.
   rsp_word_type pending_chars [$];

   int fail_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   row_type directed [DIRECTED_ROWS];

   // Encodes one byte into the shadow state. The return value is the number
   // of characters left in next_group: zero while a group is still filling.
   function automatic int encode_byte(input logic [7:0] raw, input logic fin);
      logic [7:0]  b;
      logic [23:0] grp;
      int          n;
      b = (scrub_cr && raw == CR_BYTE) ? SPACE_BYTE : raw;
      n = 0;
      grp = '0;
      if (held_n == GRP_TWO) begin
         // The third byte always closes the group, marked last or not.
         grp = {held_pair, b};
         n = 3;
      end else begin
         held_pair = {held_pair[7:0], b};
         held_n = held_n + 2'd1;
         if (fin) begin
            // A short final group is left-aligned, with zeros below it.
            grp = (held_n == GRP_ONE) ? {held_pair[7:0], 16'h0000} : {held_pair, 8'h00};
            n = held_n;
         end
      end
      if (n == 0) begin
         return 0;
      end
      // A group of n bytes carries n + 1 real characters, and pads fill the rest.
      for (int k = 0; k < 4; k++) begin
         next_group[k].code_char = (k <= n) ? 7'(b64_set[grp[23 - 6 * k -: 6]]) : PAD_CHAR;
         next_group[k].last_char = fin && (k == 3);
      end
      held_pair = '0;
      held_n = '0;
      return 4;
   endfunction

   // Carriage returns, line feeds and the byte extremes show up far more often
   // than they would in a flat draw.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0, 1: begin
            return CR_BYTE;
         end
         2: begin
            return 8'h0a;
         end
         3: begin
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   // Sends one word and returns in the time step of its acceptance, with valid
   // still high, so that back-to-back words never drop valid in between. Each
   // burst ends with an idle gap of random length, which is sometimes zero.
   task automatic send_word(input logic [7:0] raw, input logic fin, input logic [31:0] typed);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= '{data_byte: raw, last_byte: fin};
      do begin
         @(posedge clock);
      end while (req_stall);
      if (encode_byte(raw, fin) != 0) begin
         for (int k = 0; k < 4; k++) begin
            if (typed != NO_TYPED) begin
               next_group[k].code_char = typed[(3 - k) * 8 +: 7];
            end
            pending_chars.push_back(next_group[k]);
         end
      end
   endtask

   // Drops valid, waits for every owed character and then lets the block settle.
   task automatic drain_block();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The scrub register changes only while the block is idle.
   task automatic write_scrub(input logic value);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scrub_cr = value;
   endtask

   // Directed rows. Where the characters are obvious they are given as a string.
   // Every other row relies on the shadow encoder.
   initial begin
      directed = '{
         // Scrubbing is on from reset. The rows cover one-byte finals at both
         // extremes, full groups of all ones and all zeros, and a scrubbed CR.
         {ROW_WORD, 8'h00, 1'b1, "AA=="},
         {ROW_WORD, 8'hff, 1'b1, "/w=="},
         {ROW_WORD, 8'hff, 1'b0, NO_TYPED},
         {ROW_WORD, 8'hff, 1'b0, NO_TYPED},
         {ROW_WORD, 8'hff, 1'b0, "////"},
         {ROW_WORD, 8'h00, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h00, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h00, 1'b1, "AAAA"},
         {ROW_WORD, CR_BYTE, 1'b1, "IA=="},
         // The next rows cover a two-byte final with one pad, then a plain full group.
         {ROW_WORD, 8'h4d, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h61, 1'b1, "TWE="},
         {ROW_WORD, 8'h4d, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h61, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h6e, 1'b0, "TWFu"},
         // A group of three carriage returns is scrubbed to three spaces.
         {ROW_WORD, CR_BYTE, 1'b0, NO_TYPED},
         {ROW_WORD, CR_BYTE, 1'b0, NO_TYPED},
         {ROW_WORD, CR_BYTE, 1'b0, "ICAg"},
         // With scrubbing off, a carriage return passes through as it is.
         {ROW_CSR,  8'h00, 1'b0, NO_TYPED},
         {ROW_WORD, CR_BYTE, 1'b1, "DQ=="},
         {ROW_WORD, CR_BYTE, 1'b0, NO_TYPED},
         {ROW_WORD, 8'h0a, 1'b0, NO_TYPED},
         {ROW_WORD, CR_BYTE, 1'b1, "DQoN"},
         // This group encodes to four '+' characters, the one the other rows miss.
         {ROW_WORD, 8'hfb, 1'b0, NO_TYPED},
         {ROW_WORD, 8'hef, 1'b0, NO_TYPED},
         {ROW_WORD, 8'hbe, 1'b0, "++++"},
         {ROW_CSR,  8'h01, 1'b0, NO_TYPED}
      };
   end

   // Stimulus: reset, then the directed rows, then random blobs in phases
   // that each start with a register write. Every blob ends on a last byte,
   // so the block holds no bytes when a phase ends.
   initial begin : stimulus
      int sent;
      int blob_len;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (directed[r].kind == ROW_CSR) begin
            write_scrub(directed[r].data_byte[0]);
         end else begin
            send_word(directed[r].data_byte, directed[r].fin, directed[r].typed);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         // The first two phases use both register values, and later ones draw at random.
         write_scrub((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
         sent = 0;
         while (sent < PHASE_BYTES) begin
            // Most blobs are short. Now and then a long one runs many groups in a row.
            blob_len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 24)
                                                    : $urandom_range(1, 6);
            for (int k = 1; k <= blob_len; k++) begin
               send_word(pick_byte(), k == blob_len, NO_TYPED);
            end
            sent += blob_len;
         end
      end

      drain_block();
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Result side. Each accepted character is checked against the oldest owed
   // one. The stall mode is then redrawn whenever stall_age wraps: none, light random,
   // heavy random or a fixed period.
   stall_mode_e stall_mode = STALL_NONE;
   int          stall_age = 0;

   always @(posedge clock) begin : rsp_side
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_chars.size() == 0) begin
            $error("code_char: no character expected, got %h", rsp_data.code_char);
            fail_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_data.code_char !== want.code_char) begin
               $error("code_char: expected %h, actual %h", want.code_char, rsp_data.code_char);
               fail_count++;
            end
            if (rsp_data.last_char !== want.last_char) begin
               $error("last_char: expected %b, actual %b", want.last_char, rsp_data.last_char);
               fail_count++;
            end
         end
      end

      stall_age++;
      if (stall_age == 48) begin
         stall_age = 0;
         stall_mode = stall_mode_e'($urandom_range(0, 3));
      end
      case (stall_mode)
         STALL_NONE: begin
            rsp_stall <= 1'b0;
         end
         STALL_LIGHT: begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
         end
         STALL_HEAVY: begin
            rsp_stall <= ($urandom_range(0, 3) != 0);
         end
         default: begin
            rsp_stall <= (cycle_count % 8 >= 5);
         end
      endcase
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
